### rtl/core/assert_macros.svh
// assertion helpers shared by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/w5r_pkg.sv
package w5r_pkg;

   // cell and result width, q16.16
   localparam int DATA_W = 32;
   localparam int CAND_N = 3;
   localparam int SMP_N = 2 * CAND_N;

   // six times a candidate value
   localparam int Q_W = 37;
   // stencil differences and their magnitudes
   localparam int DIF_W = 35;
   localparam int MAG_W = 34;
   localparam int HALF_W = 17;
   localparam int PP_W = 2 * HALF_W;
   localparam int SQ_W = 2 * MAG_W;

   // twelve times (eps + beta)
   localparam int S_W = 72;
   localparam int EPS_W = 32;
   localparam int BETA_C2 = 13;
   localparam int BETA_C1 = 3;
   localparam int EPS_MUL = 12;

   // leading one search
   localparam int GRP_W = 8;
   localparam int GRP_N = S_W / GRP_W;
   localparam int LM_W = 3;
   localparam int P_W = 7;
   localparam int NORM_TOP = 15;
   localparam int LSH = 12;
   localparam int SH_W = S_W + LSH;

   // normalized indicators and their squares
   localparam int NRM_W = 32;
   localparam int NSQ_W = 2 * NRM_W;
   localparam int RNUM_W = 63;
   localparam int R_W = 33;

   // weights
   localparam int A_W = 36;
   localparam int ALPHA_G1 = 6;
   localparam int ALPHA_G2 = 3;
   localparam int W_FRAC = 26;
   localparam int WQ_W = W_FRAC + 1;
   localparam int WNUM_W = 61;
   localparam logic [WQ_W-1:0] W_ONE = {1'b1, {W_FRAC{1'b0}}};

   // weighted sum
   localparam int QL_W = 19;
   localparam int QH_W = Q_W - QL_W;
   localparam int PR_W = WQ_W + QL_W;
   localparam int FR_W = 66;
   localparam logic [FR_W-1:0] W_RND = {{(FR_W-W_FRAC-2){1'b0}}, 2'b11, {W_FRAC{1'b0}}};

   // final divide by six and saturation
   localparam int N2_W = FR_W - W_FRAC;
   localparam logic signed [N2_W-1:0] SAT_LIM = 40'sd12884901888;
   localparam int U_W = 35;
   localparam int V_W = U_W - 1;
   localparam int RCP_W = 34;
   localparam logic [RCP_W-1:0] RECIP3 = 34'd11453246123;
   localparam int RECIP3_SH = 35;
   localparam int MP_W = HALF_W + RCP_W;
   localparam int PRD_W = V_W + RCP_W;
   localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [EPS_W-1:0] EPS_RESET = 32'd4295;

   typedef struct packed {
      logic signed [DATA_W-1:0] cell_m2;
      logic signed [DATA_W-1:0] cell_m1;
      logic signed [DATA_W-1:0] cell_c;
      logic signed [DATA_W-1:0] cell_p1;
      logic signed [DATA_W-1:0] cell_p2;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] face_flux;
      logic                     saturated;
   } rsp_type;

endpackage

### rtl/core/w5r_div.sv
`include "assert_macros.svh"

// pipelined restoring divider, one quotient bit per stage, several lanes
// the caller guarantees num < den * 2^QUO_W in every lane
module w5r_div #(
   parameter int LANES = 1,
   parameter int NUM_W = 8,
   parameter int DEN_W = 8,
   parameter int QUO_W = 8,
   parameter int SIDE_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]  in_num,
   input  logic [LANES-1:0][DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic [LANES-1:0][QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0]            out_side
);

   localparam int CW = DEN_W + QUO_W;

   logic                        vld_ff  [QUO_W];
   logic [LANES-1:0][CW-1:0]    rem_ff  [QUO_W];
   logic [LANES-1:0][DEN_W-1:0] den_ff  [QUO_W];
   logic [LANES-1:0][QUO_W-1:0] quo_ff  [QUO_W];
   logic [SIDE_W-1:0]           side_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic                        vld_cur;
      logic [LANES-1:0][CW-1:0]    rem_cur;
      logic [LANES-1:0][DEN_W-1:0] den_cur;
      logic [LANES-1:0][QUO_W-1:0] quo_cur;
      logic [SIDE_W-1:0]           side_cur;
      logic [LANES-1:0][CW-1:0]    rem_in;
      logic [LANES-1:0][QUO_W-1:0] quo_in;

      // stage input: ports for the first stage, previous stage otherwise
      if (j == 0) begin : g_head
         always_comb begin
            vld_cur = in_valid;
            side_cur = in_side;
            den_cur = in_den;
            for (int l = 0; l < LANES; l++) begin
               rem_cur[l] = CW'(in_num[l]);
               quo_cur[l] = '0;
            end
         end
      end else begin : g_body
         assign vld_cur = vld_ff[j-1];
         assign rem_cur = rem_ff[j-1];
         assign den_cur = den_ff[j-1];
         assign quo_cur = quo_ff[j-1];
         assign side_cur = side_ff[j-1];
      end

      // trial subtract of the divisor at this quotient bit
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            quo_in[l] = quo_cur[l];
            if (rem_cur[l] >= (CW'(den_cur[l]) << (QUO_W - 1 - j))) begin
               rem_in[l] = rem_cur[l] - (CW'(den_cur[l]) << (QUO_W - 1 - j));
               quo_in[l][QUO_W-1-j] = 1'b1;
            end else begin
               rem_in[l] = rem_cur[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_cur;
            quo_ff[j] <= quo_in;
            side_ff[j] <= side_cur;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo = quo_ff[QUO_W-1];
   assign out_side = side_ff[QUO_W-1];

   `ASSERT_NEXT(a_hold_on_stall, !en, out_valid == $past(out_valid), "divider moved while held")
   `ASSERT_NEXT(a_first_valid, en, vld_ff[0] == $past(in_valid), "divider lost an entering beat")
   for (genvar l = 0; l < LANES; l++) begin : g_chk
      `ASSERT_CLK(a_rem_bound, !out_valid || (rem_ff[QUO_W-1][l] < CW'(den_ff[QUO_W-1][l])), "divider remainder not below divisor")
   end

endmodule

### rtl/core/weno5_flux_reconstruction.sv
`include "assert_macros.svh"

// Fifth-order WENO reconstruction of the flux at the right face of cell i from the
// five cells i-2 .. i+2, all signed Q16.16. One stencil is accepted every cycle while
// req_stall is low and results come out in order; their delay is set mostly by the
// two pipelined dividers (33 stages for the inverse squared smoothness indicators,
// 27 stages for the weight normalization). A stall on the result side
// freezes the whole pipeline and is passed straight back as req_stall. The
// epsilon register (units of 2^-32, zero acts as one) is written through the csr
// port, which is always ready, and should be changed only while the block is empty.
module weno5_flux_reconstruction (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  w5r_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output w5r_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);

   import w5r_pkg::*;

   logic adv;

   // epsilon register
   logic [EPS_W-1:0] eps_ff;
   logic [EPS_W-1:0] eps_eff;

   // stage valids
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   logic s6_vld_ff, s7_vld_ff, s8_vld_ff, s9_vld_ff, s10_vld_ff;
   logic s11_vld_ff, s12_vld_ff, s13_vld_ff, s14_vld_ff, s15_vld_ff;
   logic rsp_valid_ff;

   // stage payloads
   req_type                  s1_cell_ff;
   logic [MAG_W-1:0]         s2_mag_ff [SMP_N];
   logic [MAG_W-1:0]         s2_mag_in [SMP_N];
   logic signed [Q_W-1:0]    s2_q_ff [CAND_N];
   logic signed [Q_W-1:0]    s2_q_in [CAND_N];
   logic [PP_W-1:0]          s3_hh_ff [SMP_N];
   logic [PP_W-1:0]          s3_hl_ff [SMP_N];
   logic [PP_W-1:0]          s3_ll_ff [SMP_N];
   logic [PP_W-1:0]          s3_hh_in [SMP_N];
   logic [PP_W-1:0]          s3_hl_in [SMP_N];
   logic [PP_W-1:0]          s3_ll_in [SMP_N];
   logic signed [Q_W-1:0]    s3_q_ff [CAND_N];
   logic [SQ_W-1:0]          s4_sq_ff [SMP_N];
   logic [SQ_W-1:0]          s4_sq_in [SMP_N];
   logic signed [Q_W-1:0]    s4_q_ff [CAND_N];
   logic [S_W-1:0]           s5_s_ff [CAND_N];
   logic [S_W-1:0]           s5_s_in [CAND_N];
   logic signed [Q_W-1:0]    s5_q_ff [CAND_N];
   logic [S_W-1:0]           s6_s_ff [CAND_N];
   logic [S_W-1:0]           s6_mn_ff;
   logic [S_W-1:0]           s6_mn_in;
   logic signed [Q_W-1:0]    s6_q_ff [CAND_N];
   logic [S_W-1:0]           s7_s_ff [CAND_N];
   logic [GRP_N-1:0]         s7_nz_ff;
   logic [GRP_N-1:0]         s7_nz_in;
   logic [LM_W-1:0]          s7_lm_ff [GRP_N];
   logic [LM_W-1:0]          s7_lm_in [GRP_N];
   logic signed [Q_W-1:0]    s7_q_ff [CAND_N];
   logic [S_W-1:0]           s8_s_ff [CAND_N];
   logic [P_W-1:0]           s8_amt_ff;
   logic [P_W-1:0]           s8_amt_in;
   logic signed [Q_W-1:0]    s8_q_ff [CAND_N];
   logic [NRM_W-1:0]         s9_nrm_ff [CAND_N];
   logic [NRM_W-1:0]         s9_nrm_in [CAND_N];
   logic signed [Q_W-1:0]    s9_q_ff [CAND_N];
   logic [CAND_N-1:0][NSQ_W-1:0] s10_nsq_ff;
   logic [CAND_N-1:0][NSQ_W-1:0] s10_nsq_in;
   logic signed [Q_W-1:0]    s10_q_ff [CAND_N];

   // inverse squared indicator divider
   logic [CAND_N-1:0][RNUM_W-1:0] divr_num;
   logic [CAND_N*Q_W-1:0]         divr_side_in;
   logic                          divr_vld;
   logic [CAND_N-1:0][R_W-1:0]    divr_quo;
   logic [CAND_N*Q_W-1:0]         divr_side;

   logic [1:0][WNUM_W-1:0]   s11_num_ff;
   logic [1:0][WNUM_W-1:0]   s11_num_in;
   logic [A_W-1:0]           s11_sum_ff;
   logic [A_W-1:0]           s11_sum_in;
   logic [CAND_N*Q_W-1:0]    s11_q_ff;

   // weight divider
   logic [1:0][A_W-1:0]      divw_den;
   logic                     divw_vld;
   logic [1:0][WQ_W-1:0]     divw_quo;
   logic [CAND_N*Q_W-1:0]    divw_side;

   logic [PR_W-1:0]          s12_pl_ff [CAND_N];
   logic [PR_W-1:0]          s12_pl_in [CAND_N];
   logic signed [PR_W-1:0]   s12_ph_ff [CAND_N];
   logic signed [PR_W-1:0]   s12_ph_in [CAND_N];
   logic [FR_W-1:0]          s13_num_ff;
   logic [FR_W-1:0]          s13_num_in;
   logic [V_W-1:0]           s14_v_ff;
   logic [V_W-1:0]           s14_v_in;
   logic                     s14_sat_ff;
   logic                     s14_sat_in;
   logic [MP_W-1:0]          s15_pa_ff;
   logic [MP_W-1:0]          s15_pb_ff;
   logic [MP_W-1:0]          s15_pa_in;
   logic [MP_W-1:0]          s15_pb_in;
   logic                     s15_sat_ff;
   rsp_type                  rsp_data_ff;
   rsp_type                  rsp_data_in;

   // whole pipeline moves unless a finished result is held back
   assign adv = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign csr_ready = 1'b1;

   // configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_valid) begin
         eps_ff <= csr_data;
      end
   end

   assign eps_eff = (eps_ff == '0) ? EPS_W'(1) : eps_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
         s9_vld_ff <= 1'b0;
         s10_vld_ff <= 1'b0;
         s11_vld_ff <= 1'b0;
         s12_vld_ff <= 1'b0;
         s13_vld_ff <= 1'b0;
         s14_vld_ff <= 1'b0;
         s15_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
         s8_vld_ff <= s7_vld_ff;
         s9_vld_ff <= s8_vld_ff;
         s10_vld_ff <= s9_vld_ff;
         s11_vld_ff <= divr_vld;
         s12_vld_ff <= divw_vld;
         s13_vld_ff <= s12_vld_ff;
         s14_vld_ff <= s13_vld_ff;
         s15_vld_ff <= s14_vld_ff;
         rsp_valid_ff <= s15_vld_ff;
      end
   end

   // stage 2: candidates and stencil differences
   always_comb begin
      logic signed [DIF_W-1:0] xa, xb, xc, xd, xe;
      logic signed [DIF_W-1:0] dif [SMP_N];
      logic signed [Q_W-1:0]   ya, yb, yc, yd, ye;
      xa = DIF_W'(s1_cell_ff.cell_m2);
      xb = DIF_W'(s1_cell_ff.cell_m1);
      xc = DIF_W'(s1_cell_ff.cell_c);
      xd = DIF_W'(s1_cell_ff.cell_p1);
      xe = DIF_W'(s1_cell_ff.cell_p2);
      ya = Q_W'(s1_cell_ff.cell_m2);
      yb = Q_W'(s1_cell_ff.cell_m1);
      yc = Q_W'(s1_cell_ff.cell_c);
      yd = Q_W'(s1_cell_ff.cell_p1);
      ye = Q_W'(s1_cell_ff.cell_p2);
      dif[0] = xa - 2 * xb + xc;
      dif[1] = xa - 4 * xb + 3 * xc;
      dif[2] = xb - 2 * xc + xd;
      dif[3] = xb - xd;
      dif[4] = xc - 2 * xd + xe;
      dif[5] = 3 * xc - 4 * xd + xe;
      for (int i = 0; i < SMP_N; i++) begin
         s2_mag_in[i] = dif[i][DIF_W-1] ? MAG_W'(-dif[i]) : MAG_W'(dif[i]);
      end
      s2_q_in[0] = 2 * ya - 7 * yb + 11 * yc;
      s2_q_in[1] = -yb + 5 * yc + 2 * yd;
      s2_q_in[2] = 2 * yc + 5 * yd - ye;
   end

   // stage 3: partial products of the squares
   always_comb begin
      logic [HALF_W-1:0] uh, ul;
      for (int i = 0; i < SMP_N; i++) begin
         uh = s2_mag_ff[i][MAG_W-1:HALF_W];
         ul = s2_mag_ff[i][HALF_W-1:0];
         s3_hh_in[i] = PP_W'(uh) * PP_W'(uh);
         s3_hl_in[i] = PP_W'(uh) * PP_W'(ul);
         s3_ll_in[i] = PP_W'(ul) * PP_W'(ul);
      end
   end

   // stage 4: squares
   always_comb begin
      for (int i = 0; i < SMP_N; i++) begin
         s4_sq_in[i] = (SQ_W'(s3_hh_ff[i]) << (2 * HALF_W))
                     + (SQ_W'(s3_hl_ff[i]) << (HALF_W + 1))
                     + SQ_W'(s3_ll_ff[i]);
      end
   end

   // stage 5: twelve times (eps + beta)
   always_comb begin
      for (int k = 0; k < CAND_N; k++) begin
         s5_s_in[k] = S_W'(s4_sq_ff[2*k]) * S_W'(BETA_C2)
                    + S_W'(s4_sq_ff[2*k+1]) * S_W'(BETA_C1)
                    + S_W'(eps_eff) * S_W'(EPS_MUL);
      end
   end

   // stage 6: smallest indicator
   always_comb begin
      logic [S_W-1:0] m01;
      m01 = (s5_s_ff[1] < s5_s_ff[0]) ? s5_s_ff[1] : s5_s_ff[0];
      s6_mn_in = (s5_s_ff[2] < m01) ? s5_s_ff[2] : m01;
   end

   // stage 7: leading one inside each byte
   always_comb begin
      for (int g = 0; g < GRP_N; g++) begin
         s7_nz_in[g] = |s6_mn_ff[g*GRP_W +: GRP_W];
         s7_lm_in[g] = '0;
         for (int b = 0; b < GRP_W; b++) begin
            if (s6_mn_ff[g*GRP_W + b]) begin
               s7_lm_in[g] = LM_W'(b);
            end
         end
      end
   end

   // stage 8: leading one position and normalizing shift
   always_comb begin
      logic [P_W-1:0] p;
      p = '0;
      for (int g = 0; g < GRP_N; g++) begin
         if (s7_nz_ff[g]) begin
            p = P_W'(g * GRP_W) + P_W'(s7_lm_ff[g]);
         end
      end
      s8_amt_in = p - P_W'(NORM_TOP - LSH);
   end

   // stage 9: common shift, clamp to 32 bits, floor at one
   always_comb begin
      logic [SH_W-1:0] t;
      for (int k = 0; k < CAND_N; k++) begin
         t = {s8_s_ff[k], {LSH{1'b0}}} >> s8_amt_ff;
         s9_nrm_in[k] = (|t[SH_W-1:NRM_W]) ? '1 : t[NRM_W-1:0];
         if (s9_nrm_in[k] == '0) begin
            s9_nrm_in[k] = NRM_W'(1);
         end
      end
   end

   // stage 10: squares of the normalized indicators
   always_comb begin
      for (int k = 0; k < CAND_N; k++) begin
         s10_nsq_in[k] = NSQ_W'(s9_nrm_ff[k]) * NSQ_W'(s9_nrm_ff[k]);
      end
   end

   // stages 1 to 10 registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cell_ff <= req_data;
         s2_mag_ff <= s2_mag_in;
         s2_q_ff <= s2_q_in;
         s3_hh_ff <= s3_hh_in;
         s3_hl_ff <= s3_hl_in;
         s3_ll_ff <= s3_ll_in;
         s3_q_ff <= s2_q_ff;
         s4_sq_ff <= s4_sq_in;
         s4_q_ff <= s3_q_ff;
         s5_s_ff <= s5_s_in;
         s5_q_ff <= s4_q_ff;
         s6_s_ff <= s5_s_ff;
         s6_mn_ff <= s6_mn_in;
         s6_q_ff <= s5_q_ff;
         s7_s_ff <= s6_s_ff;
         s7_nz_ff <= s7_nz_in;
         s7_lm_ff <= s7_lm_in;
         s7_q_ff <= s6_q_ff;
         s8_s_ff <= s7_s_ff;
         s8_amt_ff <= s8_amt_in;
         s8_q_ff <= s7_q_ff;
         s9_nrm_ff <= s9_nrm_in;
         s9_q_ff <= s8_q_ff;
         s10_nsq_ff <= s10_nsq_in;
         s10_q_ff <= s9_q_ff;
      end
   end

   // 2^62 / s^2 for each candidate
   always_comb begin
      for (int k = 0; k < CAND_N; k++) begin
         divr_num[k] = {1'b1, {(RNUM_W-1){1'b0}}};
      end
      divr_side_in = {s10_q_ff[2], s10_q_ff[1], s10_q_ff[0]};
   end

   w5r_div #(
      .LANES  (CAND_N),
      .NUM_W  (RNUM_W),
      .DEN_W  (NSQ_W),
      .QUO_W  (R_W),
      .SIDE_W (CAND_N * Q_W)
   ) u_divr (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s10_vld_ff),
      .in_num    (divr_num),
      .in_den    (s10_nsq_ff),
      .in_side   (divr_side_in),
      .out_valid (divr_vld),
      .out_quo   (divr_quo),
      .out_side  (divr_side)
   );

   // stage 11: unnormalized weights and their sum
   always_comb begin
      logic [A_W-1:0] al0, al1, al2;
      al0 = A_W'(divr_quo[0]);
      al1 = A_W'(divr_quo[1]) * A_W'(ALPHA_G1);
      al2 = A_W'(divr_quo[2]) * A_W'(ALPHA_G2);
      s11_sum_in = al0 + al1 + al2;
      s11_num_in[0] = WNUM_W'(al0) << W_FRAC;
      s11_num_in[1] = WNUM_W'(al1) << W_FRAC;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s11_num_ff <= s11_num_in;
         s11_sum_ff <= s11_sum_in;
         s11_q_ff <= divr_side;
      end
   end

   assign divw_den[0] = s11_sum_ff;
   assign divw_den[1] = s11_sum_ff;

   w5r_div #(
      .LANES  (2),
      .NUM_W  (WNUM_W),
      .DEN_W  (A_W),
      .QUO_W  (WQ_W),
      .SIDE_W (CAND_N * Q_W)
   ) u_divw (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s11_vld_ff),
      .in_num    (s11_num_ff),
      .in_den    (divw_den),
      .in_side   (s11_q_ff),
      .out_valid (divw_vld),
      .out_quo   (divw_quo),
      .out_side  (divw_side)
   );

   // stage 12: weight times candidate, split into partial products
   always_comb begin
      logic [WQ_W-1:0]        w [CAND_N];
      logic signed [Q_W-1:0]  q;
      logic [QL_W-1:0]        ql;
      logic signed [QH_W-1:0] qh;
      w[0] = divw_quo[0];
      w[1] = divw_quo[1];
      w[2] = W_ONE - divw_quo[0] - divw_quo[1];
      for (int k = 0; k < CAND_N; k++) begin
         q = divw_side[k*Q_W +: Q_W];
         ql = q[QL_W-1:0];
         qh = q[Q_W-1:QL_W];
         s12_pl_in[k] = PR_W'(w[k]) * PR_W'(ql);
         s12_ph_in[k] = $signed({1'b0, w[k]}) * qh;
      end
   end

   // stage 13: weighted sum plus rounding offset
   always_comb begin
      s13_num_in = W_RND;
      for (int k = 0; k < CAND_N; k++) begin
         s13_num_in = s13_num_in + (FR_W'(s12_ph_ff[k]) << QL_W) + FR_W'(s12_pl_ff[k]);
      end
   end

   // stage 14: drop weight fraction, saturate, bias to non-negative, halve
   always_comb begin
      logic signed [N2_W-1:0] n2, n2c, u;
      n2 = $signed(s13_num_ff[FR_W-1:W_FRAC]);
      s14_sat_in = 1'b0;
      n2c = n2;
      if (n2 >= SAT_LIM) begin
         n2c = SAT_LIM - N2_W'(1);
         s14_sat_in = 1'b1;
      end else if (n2 < -SAT_LIM) begin
         n2c = -SAT_LIM;
         s14_sat_in = 1'b1;
      end
      u = n2c + SAT_LIM;
      s14_v_in = u[U_W-1:1];
   end

   // stage 15: divide by three through the reciprocal, partial products
   always_comb begin
      s15_pa_in = MP_W'(s14_v_ff[V_W-1:HALF_W]) * MP_W'(RECIP3);
      s15_pb_in = MP_W'(s14_v_ff[HALF_W-1:0]) * MP_W'(RECIP3);
   end

   // output: finish the product, remove the bias
   always_comb begin
      logic [PRD_W-1:0]  prod;
      logic [DATA_W-1:0] t;
      prod = (PRD_W'(s15_pa_ff) << HALF_W) + PRD_W'(s15_pb_ff);
      t = prod[RECIP3_SH + DATA_W - 1:RECIP3_SH];
      rsp_data_in.face_flux = $signed(t ^ SIGN_FLIP);
      rsp_data_in.saturated = s15_sat_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s12_pl_ff <= s12_pl_in;
         s12_ph_ff <= s12_ph_in;
         s13_num_ff <= s13_num_in;
         s14_v_ff <= s14_v_in;
         s14_sat_ff <= s14_sat_in;
         s15_pa_ff <= s15_pa_in;
         s15_pb_ff <= s15_pb_in;
         s15_sat_ff <= s14_sat_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   `ASSERT_CLK(a_weight_sum, !divw_vld || ((WQ_W+1)'(divw_quo[0]) + (WQ_W+1)'(divw_quo[1]) <= (WQ_W+1)'(W_ONE)), "weights exceed one")
   `ASSERT_CLK(a_norm_floor, !s9_vld_ff || (s9_nrm_ff[0][NORM_TOP+1:0] != '0 || s9_nrm_ff[0] >= (NRM_W'(1) << NORM_TOP)), "normalized indicator below floor")
   `ASSERT_CLK(a_norm_min, !s9_vld_ff || (s9_nrm_ff[0] < (NRM_W'(1) << (NORM_TOP+1))) || (s9_nrm_ff[1] < (NRM_W'(1) << (NORM_TOP+1))) || (s9_nrm_ff[2] < (NRM_W'(1) << (NORM_TOP+1))), "no indicator normalized to top bit")
   `ASSERT_CLK(a_sat_value, !(rsp_valid && rsp_data.saturated) || (rsp_data.face_flux == $signed(SIGN_FLIP)) || (rsp_data.face_flux == $signed(~SIGN_FLIP)), "saturated result not at a limit")

endmodule
